// ===== rtl/core/upq_pkg.sv =====
// Package for the unsorted-array min-priority queue.
// Holds capacity constants, request and status codes, and shared types.
// No dependencies.
package upq_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ITEM_W   = 16;
    localparam int PRIO_W   = 32;

    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_DEL = 2'd1,
        REQ_UPD = 2'd2,
        REQ_QRY = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [ITEM_W-1:0]        item;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic [ITEM_W-1:0] result_item;
        t_status           status;
        logic              found;
        logic              queue_empty;
    } t_result;

endpackage

// ===== rtl/core/upq_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Read data is registered and appears in the cycle after the read is issued. No dependencies.
module upq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/upq_ctrl.sv =====
// Sequencer of the priority queue: accepts a request, scans the entry RAM
// and writes entries back. Depends on upq_pkg.
module upq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  upq_pkg::t_req                 i_req,
    input  logic [upq_pkg::ITEM_W-1:0]    i_item,
    input  logic [upq_pkg::PRIO_W-1:0]    i_prio,
    input  logic                          i_out_free,
    output logic                          o_res_valid,
    output upq_pkg::t_result              o_result,
    output logic                          o_wr_en,
    output logic [upq_pkg::ADDR_W-1:0]    o_wr_addr,
    output upq_pkg::t_entry               o_wr_data,
    output logic                          o_rd_en,
    output logic [upq_pkg::ADDR_W-1:0]    o_rd_addr,
    input  upq_pkg::t_entry               i_rd_data
);

    upq_pkg::t_state                  r_state, n_state;
    logic [upq_pkg::CNT_W-1:0]        r_count, n_count;
    upq_pkg::t_req                    r_req, n_req;
    logic [upq_pkg::ITEM_W-1:0]       r_key, n_key;
    logic [upq_pkg::PRIO_W-1:0]       r_prio, n_prio;
    logic [upq_pkg::ADDR_W-1:0]       r_idx, n_idx;
    logic                             r_pend, n_pend;
    logic [upq_pkg::ADDR_W-1:0]       r_pidx, n_pidx;
    logic [upq_pkg::ADDR_W-1:0]       r_best_idx, n_best_idx;
    logic [upq_pkg::PRIO_W-1:0]       r_best_prio, n_best_prio;
    logic [upq_pkg::ITEM_W-1:0]       r_best_item, n_best_item;
    logic                             r_found, n_found;
    logic [upq_pkg::ITEM_W-1:0]       r_res_item, n_res_item;
    upq_pkg::t_status                 r_status, n_status;

    logic                             accept;
    logic                             is_full;
    logic [upq_pkg::ADDR_W-1:0]       last_idx;
    logic                             take_best;
    logic                             match;
    logic [upq_pkg::ADDR_W-1:0]       cur_best_idx;
    logic [upq_pkg::ITEM_W-1:0]       cur_best_item;

    assign accept   = i_in_valid && o_in_ready;
    assign is_full  = (r_count >= upq_pkg::CNT_W'(upq_pkg::CAPACITY));
    assign last_idx = upq_pkg::ADDR_W'(r_count - upq_pkg::CNT_W'(1));

    // The word under evaluation is the read issued in the previous cycle.
    assign take_best = (r_pidx == '0) ||
                       ($signed(i_rd_data.prio) < $signed(r_best_prio));
    assign match         = (i_rd_data.item == r_key);
    assign cur_best_idx  = take_best ? r_pidx : r_best_idx;
    assign cur_best_item = take_best ? i_rd_data.item : r_best_item;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            upq_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req == upq_pkg::REQ_ENQ || r_count == '0) begin
                        n_state = upq_pkg::S_FINISH;
                    end else begin
                        n_state = upq_pkg::S_SCAN;
                    end
                end
            end
            upq_pkg::S_SCAN: begin
                if (r_idx == last_idx) begin
                    n_state = upq_pkg::S_DRAIN;
                end
            end
            upq_pkg::S_DRAIN: begin
                n_state = upq_pkg::S_FINISH;
            end
            upq_pkg::S_FINISH: begin
                if (i_out_free) begin
                    n_state = upq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = upq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: handshake and RAM ports. Writes never hit an address that a
    // pending read still needs, so no forwarding is required.
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_pidx;
        o_wr_data   = i_rd_data;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx;
        case (r_state)
            upq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_req == upq_pkg::REQ_ENQ && !is_full) begin
                    o_wr_en        = 1'b1;
                    o_wr_addr      = upq_pkg::ADDR_W'(r_count);
                    o_wr_data.item = i_item;
                    o_wr_data.prio = i_prio;
                end
            end
            upq_pkg::S_SCAN: begin
                o_rd_en = 1'b1;
                if (r_pend && r_req == upq_pkg::REQ_UPD && match) begin
                    o_wr_en        = 1'b1;
                    o_wr_data.prio = r_prio;
                end
            end
            upq_pkg::S_DRAIN: begin
                if (r_req == upq_pkg::REQ_UPD && match) begin
                    o_wr_en        = 1'b1;
                    o_wr_data.prio = r_prio;
                end else if (r_req == upq_pkg::REQ_DEL) begin
                    // The last entry is the word now on the read port; move it
                    // into the winner's slot.
                    o_wr_en   = 1'b1;
                    o_wr_addr = cur_best_idx;
                end
            end
            upq_pkg::S_FINISH: begin
                o_res_valid = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_count     = r_count;
        n_req       = r_req;
        n_key       = r_key;
        n_prio      = r_prio;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_best_idx  = r_best_idx;
        n_best_prio = r_best_prio;
        n_best_item = r_best_item;
        n_found     = r_found;
        n_res_item  = r_res_item;
        n_status    = r_status;

        if (r_pend) begin
            if (r_req == upq_pkg::REQ_DEL && take_best) begin
                n_best_idx  = r_pidx;
                n_best_prio = i_rd_data.prio;
                n_best_item = i_rd_data.item;
            end
            if (r_req == upq_pkg::REQ_QRY && match) begin
                n_found = 1'b1;
            end
        end

        case (r_state)
            upq_pkg::S_IDLE: begin
                if (accept) begin
                    n_req      = i_req;
                    n_key      = i_item;
                    n_prio     = i_prio;
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    n_found    = 1'b0;
                    n_res_item = '0;
                    n_status   = upq_pkg::STAT_DONE;
                    if (i_req == upq_pkg::REQ_ENQ) begin
                        if (is_full) begin
                            n_status = upq_pkg::STAT_FULL;
                        end else begin
                            n_count = r_count + upq_pkg::CNT_W'(1);
                        end
                    end else if (i_req == upq_pkg::REQ_DEL && r_count == '0) begin
                        n_status = upq_pkg::STAT_EMPTY;
                    end
                end
            end
            upq_pkg::S_SCAN: begin
                n_pend = 1'b1;
                n_pidx = r_idx;
                n_idx  = r_idx + upq_pkg::ADDR_W'(1);
            end
            upq_pkg::S_DRAIN: begin
                n_pend = 1'b0;
                if (r_req == upq_pkg::REQ_DEL) begin
                    n_res_item = cur_best_item;
                    n_count    = r_count - upq_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= upq_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_key       <= n_key;
        r_prio      <= n_prio;
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_best_idx  <= n_best_idx;
        r_best_prio <= n_best_prio;
        r_best_item <= n_best_item;
        r_found     <= n_found;
        r_res_item  <= n_res_item;
        r_status    <= n_status;
    end

    assign o_result.result_item = r_res_item;
    assign o_result.status      = r_status;
    assign o_result.found       = r_found;
    assign o_result.queue_empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= upq_pkg::CNT_W'(upq_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req == upq_pkg::REQ_ENQ && is_full) |=> $stable(r_count))
        else $error("enqueue into full queue changed the count");

    a_no_write_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == upq_pkg::S_FINISH) |-> !o_wr_en)
        else $error("RAM write while a result is pending");

    a_drain_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == upq_pkg::S_DRAIN) |-> r_pend)
        else $error("drain without a pending read word");

endmodule

// ===== rtl/core/unsorted_array_min_priority_queue.sv =====
// Min-priority queue over an unsorted table held in one synchronous RAM.
// Enqueue, and any request on an empty queue, go straight from acceptance to the result state.
// Delete-min, update and query with n live entries issue n scan reads, then pass through a
// drain state and the result state before the next word is taken. A result waiting in the
// output register holds back the next one. Reset clears the state, the count and the output
// valid flag; the RAM needs no clearing.
module unsorted_array_min_priority_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [upq_pkg::ITEM_W-1:0] i_item,
    input  logic [upq_pkg::PRIO_W-1:0] i_priority_req,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [upq_pkg::ITEM_W-1:0] o_result_item,
    output logic [1:0]                 o_status,
    output logic                       o_found,
    output logic                       o_queue_empty
);

    logic                         out_free;
    logic                         res_valid;
    upq_pkg::t_result             result;
    logic                         wr_en;
    logic [upq_pkg::ADDR_W-1:0]   wr_addr;
    upq_pkg::t_entry              wr_data;
    logic                         rd_en;
    logic [upq_pkg::ADDR_W-1:0]   rd_addr;
    upq_pkg::t_entry              rd_data;
    logic                         r_out_vld;
    upq_pkg::t_result             r_out;

    assign out_free = !r_out_vld || i_out_ready;

    upq_ram #(
        .WIDTH ($bits(upq_pkg::t_entry)),
        .DEPTH (upq_pkg::CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    upq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req       (upq_pkg::t_req'(i_req_type)),
        .i_item      (i_item),
        .i_prio      (i_priority_req),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_result    (result),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // Output register: holds a finished result word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_result_item = r_out.result_item;
    assign o_status      = r_out.status;
    assign o_found       = r_out.found;
    assign o_queue_empty = r_out.queue_empty;

endmodule
